FILE: sv/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);

`endif

FILE: sv/lmpw_pkg.sv
package lmpw_pkg;

  localparam int ROW_COUNT_DEF = 7;
  localparam int COLUMN_COUNT_DEF = 18;
  localparam int RED_STEP_COUNT_DEF = 42;
  localparam int GREEN_STEP_COUNT_DEF = 50;
  localparam int BLUE_STEP_COUNT_DEF = 63;
  localparam int SETUP_STEP_COUNT_DEF = 3;

  localparam logic [31:0] ROW_CLK_PIN = 32'h0000_0010;
  localparam logic [31:0] ROW_DATA_PIN = 32'h0000_1000;
  localparam logic [31:0] COLS_ON_B = 32'h0000_03E3;
  localparam logic [31:0] COLS_ON_C = 32'h0000_1FFC;
  localparam logic [31:0] ALL_ON_B = ROW_CLK_PIN | ROW_DATA_PIN | COLS_ON_B;
  localparam logic [31:0] RESET_BIT_BASE = 32'h0001_0000;

  // Item codes.
  typedef enum logic [2:0] {
    ACT_RGB332 = 3'd0,
    ACT_RGB888 = 3'd1,
    ACT_HUE    = 3'd2,
    ACT_CLEAR  = 3'd3,
    ACT_TICK   = 3'd4
  } action_t;

  // Configuration register indexes.
  localparam logic [1:0] REG_RED = 2'd0;
  localparam logic [1:0] REG_GREEN = 2'd1;
  localparam logic [1:0] REG_BLUE = 2'd2;

endpackage

FILE: sv/led_matrix_pwm_program_writer_unit.sv
// Tick: result item registered through ST_TICK and ST_HOLD, later while the previous result is held;
// the next item can be accepted in the same cycle as the result appears.
// Pixel write: color conversion (hue: quotient, sextant, products, scale, table; a division
// per component but for RGB332), then read-modify-write on the step words of one row and port.
// Clear: one word pair per cycle over all step words.
// After rst a pass over all words writes the reset image, no item is taken meanwhile.
`include "assert_macros.svh"

module led_matrix_pwm_program_writer_unit #(
  parameter int ROW_COUNT = lmpw_pkg::ROW_COUNT_DEF,
  parameter int COLUMN_COUNT = lmpw_pkg::COLUMN_COUNT_DEF,
  parameter int RED_STEP_COUNT = lmpw_pkg::RED_STEP_COUNT_DEF,
  parameter int GREEN_STEP_COUNT = lmpw_pkg::GREEN_STEP_COUNT_DEF,
  parameter int BLUE_STEP_COUNT = lmpw_pkg::BLUE_STEP_COUNT_DEF,
  parameter int SETUP_STEP_COUNT = lmpw_pkg::SETUP_STEP_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  action,
  input  logic [3:0]  row,
  input  logic [4:0]  column,
  input  logic [23:0] pixel_value,
  input  logic [9:0]  hue,
  input  logic [7:0]  brightness,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] port_b_word,
  output logic [31:0] port_c_word,
  output logic        end_of_frame,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int ROW_STEPS = RED_STEP_COUNT + GREEN_STEP_COUNT + BLUE_STEP_COUNT;
  localparam int TOTAL_WORDS = SETUP_STEP_COUNT + ROW_COUNT * ROW_STEPS;
  localparam int AW = $clog2(TOTAL_WORDS);
  localparam int SW = $clog2(ROW_STEPS + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(TOTAL_WORDS - 1);
  localparam logic [AW-1:0] FIRST_STEP = AW'(SETUP_STEP_COUNT);
  localparam logic [SW-1:0] RS = SW'(RED_STEP_COUNT);
  localparam logic [SW-1:0] GS = SW'(GREEN_STEP_COUNT);
  localparam logic [SW-1:0] BS = SW'(BLUE_STEP_COUNT);
  localparam logic [SW-1:0] RGS = SW'(RED_STEP_COUNT + GREEN_STEP_COUNT);
  localparam logic [SW-1:0] LAST_STEP = SW'(ROW_STEPS - 1);
  // 2^20 / 60 rounded up; exact for numerators up to 23831.
  localparam logic [14:0] RECIP_60 = 15'd17477;

  typedef enum logic [7:0] {
    ST_INIT  = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_TICK  = 8'b0000_0100,
    ST_HOLD  = 8'b0000_1000,
    ST_CONV  = 8'b0001_0000,
    ST_LEVEL = 8'b0010_0000,
    ST_RMW   = 8'b0100_0000,
    ST_CLEAR = 8'b1000_0000
  } state_t;

  state_t state;

  logic [7:0] red_div, green_div, blue_div;

  // Memory ports.
  logic          b_we, c_we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   b_wdata, c_wdata, b_rdata, c_rdata;

  lmpw_ram #(.WIDTH(32), .DEPTH(TOTAL_WORDS)) u_ram_b (
    .clk(clk), .we(b_we), .waddr(waddr), .wdata(b_wdata),
    .raddr(raddr), .rdata(b_rdata)
  );
  lmpw_ram #(.WIDTH(32), .DEPTH(TOTAL_WORDS)) u_ram_c (
    .clk(clk), .we(c_we), .waddr(waddr), .wdata(c_wdata),
    .raddr(raddr), .rdata(c_rdata)
  );

  logic [AW-1:0] ptr;
  logic [AW-1:0] sweep;        // init write address and clear read address
  logic          sweep_rd;     // a read issued last cycle for the clear sweep
  logic [AW-1:0] sweep_wa;
  logic [SW-1:0] init_off;     // step offset within a row during the init pass
  logic          eof_q;

  // Pixel job registers.
  logic [2:0]  job_act;
  logic [AW-1:0] base;
  logic        on_c;
  logic [31:0] setm, rstm;
  logic [7:0]  comp_r, comp_g, comp_b;
  logic [7:0]  lev_r, lev_g, lev_b;
  logic [9:0]  hue_q;
  logic [7:0]  val_q;

  // Shift-subtract divider for the level division.
  logic [15:0] dv_rem;
  logic [15:0] dv_quo;
  logic [15:0] dv_den;
  logic [4:0]  dv_cnt;
  logic        dv_busy;
  logic [2:0]  conv_phase;   // hue: 0 quotient, 1 sextant, 2 products, 3 scale, 4 table
  logic [1:0]  lev_idx;
  logic [2:0]  sextant;
  logic [5:0]  hue_rem;
  logic [4:0]  hq_q;
  logic [15:0] num_f, num_r;
  logic [7:0]  falling, rising;

  // Read-modify-write step counter and pending write.
  logic [SW-1:0] step_rd;
  logic          rd_ok;
  logic [SW-1:0] step_wr;
  logic [AW-1:0] wr_addr_q;

  logic in_acc, out_acc;
  assign in_acc = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign in_stall = !(state == ST_IDLE);

  // Reset image of one word, by address and step offset within its row.
  function automatic logic [63:0] init_word(input logic [AW-1:0] a, input logic [SW-1:0] off);
    logic [31:0] b, c;
    b = '0;
    c = '0;
    if (a == AW'(0)) begin
      b = lmpw_pkg::ROW_DATA_PIN | (lmpw_pkg::ALL_ON_B << 16);
      c = lmpw_pkg::COLS_ON_C << 16;
    end else if (a == AW'(1)) begin
      b = lmpw_pkg::ROW_CLK_PIN;
    end else if (a == AW'(2)) begin
      b = lmpw_pkg::ALL_ON_B << 16;
    end
    if (a >= FIRST_STEP) begin
      if (off == '0 || off == RS || off == RGS) begin
        b = lmpw_pkg::ROW_CLK_PIN | (lmpw_pkg::COLS_ON_B << 16);
        c = lmpw_pkg::COLS_ON_C << 16;
      end else if (off == SW'(1) || off == RS + SW'(1) || off == RGS + SW'(1)) begin
        b = lmpw_pkg::ROW_CLK_PIN << 16;
      end
    end
    return {b, c};
  endfunction

  // Step offset within a row and the level it compares against.
  logic [7:0] wr_level;
  logic [SW-1:0] wr_local;
  always_comb begin
    if (step_wr < RS) begin
      wr_level = lev_r;
      wr_local = step_wr;
    end else if (step_wr < RGS) begin
      wr_level = lev_g;
      wr_local = step_wr - RS;
    end else begin
      wr_level = lev_b;
      wr_local = step_wr - RGS;
    end
  end

  logic [31:0] rmw_src, rmw_word;
  assign rmw_src = on_c ? c_rdata : b_rdata;
  assign rmw_word = ({24'd0, wr_level} > 32'(wr_local)) ? ((rmw_src | setm) & ~rstm)
                                                       : ((rmw_src & ~setm) | rstm);

  // Memory port drive.
  logic [63:0] iw;
  assign iw = init_word(sweep, init_off);
  always_comb begin
    b_we = 1'b0;
    c_we = 1'b0;
    waddr = sweep;
    b_wdata = iw[63:32];
    c_wdata = iw[31:0];
    raddr = ptr;
    unique case (state)
      ST_INIT: begin
        b_we = 1'b1;
        c_we = 1'b1;
      end
      ST_CLEAR: begin
        raddr = sweep;
        waddr = sweep_wa;
        b_we = sweep_rd;
        c_we = sweep_rd;
        b_wdata = (b_rdata | (lmpw_pkg::COLS_ON_B << 16)) & ~lmpw_pkg::COLS_ON_B;
        c_wdata = (c_rdata | (lmpw_pkg::COLS_ON_C << 16)) & ~lmpw_pkg::COLS_ON_C;
      end
      ST_RMW: begin
        raddr = base + AW'(step_rd);
        waddr = wr_addr_q;
        b_we = rd_ok && !on_c;
        c_we = rd_ok && on_c;
        b_wdata = rmw_word;
        c_wdata = rmw_word;
      end
      default: begin
      end
    endcase
  end

  // Hue division by 60 through a reciprocal multiply.
  logic [24:0] hue_prod;
  logic [10:0] hq60;
  logic [9:0]  rem_full;
  logic [27:0] prod_f, prod_r;
  assign hue_prod = 25'(hue_q) * 25'(RECIP_60);
  assign hq60 = {hq_q, 6'd0} - {4'd0, hq_q, 2'd0};
  assign rem_full = hue_q - hq60[9:0];
  assign prod_f = 28'(num_f) * 28'(RECIP_60);
  assign prod_r = 28'(num_r) * 28'(RECIP_60);

  // Divider operand.
  logic [15:0] dv_trial;
  assign dv_trial = {dv_rem[14:0], dv_quo[15]};

  logic [7:0] lev_cap;
  always_comb begin
    unique case (lev_idx)
      2'd0: lev_cap = 8'(RED_STEP_COUNT);
      2'd1: lev_cap = 8'(GREEN_STEP_COUNT);
      default: lev_cap = 8'(BLUE_STEP_COUNT);
    endcase
  end

  logic [7:0] lev_div;
  logic [7:0] lev_comp;
  always_comb begin
    unique case (lev_idx)
      2'd0: begin lev_div = red_div; lev_comp = comp_r; end
      2'd1: begin lev_div = green_div; lev_comp = comp_g; end
      default: begin lev_div = blue_div; lev_comp = comp_b; end
    endcase
  end

  // Color components after the sextant table.
  logic [7:0] hr, hg, hb;
  always_comb begin
    hr = 8'd0;
    hg = 8'd0;
    hb = 8'd0;
    unique case (sextant)
      3'd1: begin hr = falling; hg = val_q; end
      3'd2: begin hg = val_q; hb = rising; end
      3'd3: begin hg = falling; hb = val_q; end
      3'd4: begin hr = rising; hb = val_q; end
      3'd5: begin hr = val_q; hb = falling; end
      default: begin hr = val_q; hg = rising; end
    endcase
  end

  logic [7:0] q8;
  assign q8 = (dv_quo[15:8] != 8'd0) ? 8'hFF : dv_quo[7:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      sweep <= '0;
      init_off <= '0;
      ptr <= '0;
      out_valid <= 1'b0;
      red_div <= 8'd6;
      green_div <= 8'd5;
      blue_div <= 8'd4;
      dv_busy <= 1'b0;
      rd_ok <= 1'b0;
      sweep_rd <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == lmpw_pkg::REG_RED) red_div <= cfg_data;
        if (cfg_index == lmpw_pkg::REG_GREEN) green_div <= cfg_data;
        if (cfg_index == lmpw_pkg::REG_BLUE) blue_div <= cfg_data;
      end
      if (out_acc) out_valid <= 1'b0;
      unique case (state)
        ST_INIT: begin
          sweep <= sweep + AW'(1);
          if (sweep >= FIRST_STEP) init_off <= (init_off == LAST_STEP) ? '0 : init_off + SW'(1);
          if (sweep == LAST_ADDR) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_acc) begin
            job_act <= action;
            hue_q <= hue;
            val_q <= brightness;
            comp_r <= pixel_value[23:16];
            comp_g <= pixel_value[15:8];
            comp_b <= pixel_value[7:0];
            base <= FIRST_STEP + AW'(32'(row) * ROW_STEPS);
            on_c <= (column >= 5'd2) && (column < 5'd13);
            setm <= 32'd1 << ((column >= 5'd13) ? (column - 5'd8) : column);
            rstm <= lmpw_pkg::RESET_BIT_BASE << ((column >= 5'd13) ? (column - 5'd8) : column);
            conv_phase <= 3'd0;
            lev_idx <= 2'd0;
            dv_busy <= 1'b0;
            if (action == lmpw_pkg::ACT_TICK) begin
              state <= ST_TICK;
            end else if (action == lmpw_pkg::ACT_CLEAR) begin
              sweep <= FIRST_STEP;
              sweep_rd <= 1'b0;
              state <= ST_CLEAR;
            end else if (action <= lmpw_pkg::ACT_HUE && 32'(row) < ROW_COUNT &&
                         32'(column) < COLUMN_COUNT) begin
              state <= ST_CONV;
            end
          end
        end
        ST_TICK: begin
          // Read data for the pointer arrives now and stays while the pointer holds.
          eof_q <= ptr == LAST_ADDR;
          state <= ST_HOLD;
        end
        ST_HOLD: begin
          if (!out_valid) begin
            port_b_word <= b_rdata;
            port_c_word <= c_rdata;
            end_of_frame <= eof_q;
            out_valid <= 1'b1;
            ptr <= (ptr == LAST_ADDR) ? '0 : ptr + AW'(1);
            state <= ST_IDLE;
          end
        end
        ST_CLEAR: begin
          sweep_wa <= sweep;
          if (sweep_rd && sweep_wa == LAST_ADDR) begin
            sweep_rd <= 1'b0;
            state <= ST_IDLE;
          end else begin
            sweep_rd <= 1'b1;
            if (sweep != LAST_ADDR) sweep <= sweep + AW'(1);
          end
        end
        ST_CONV: begin
          // Turn the color into 8-bit components; RGB332 maps straight to levels.
          if (job_act == lmpw_pkg::ACT_RGB332) begin
            lev_r <= 8'((16'(comp_b & 8'hE0) * 16'd6) >> 5);
            lev_g <= 8'((16'(comp_b & 8'h1C) * 16'd29) >> 4);
            lev_b <= 8'(16'(comp_b & 8'h03) * 16'd21);
            step_rd <= '0;
            rd_ok <= 1'b0;
            state <= ST_RMW;
          end else if (job_act == lmpw_pkg::ACT_RGB888) begin
            state <= ST_LEVEL;
          end else begin
            conv_phase <= conv_phase + 3'd1;
            unique case (conv_phase)
              3'd0: hq_q <= hue_prod[24:20];
              3'd1: begin
                sextant <= (hq_q > 5'd5) ? 3'd0 : hq_q[2:0];
                hue_rem <= rem_full[5:0];
              end
              3'd2: begin
                num_f <= 16'(val_q) * 16'(7'd60 - {1'b0, hue_rem});
                num_r <= 16'(val_q) * 16'(hue_rem);
              end
              3'd3: begin
                falling <= prod_f[27:20];
                rising <= prod_r[27:20];
              end
              default: begin
                comp_r <= hr;
                comp_g <= hg;
                comp_b <= hb;
                state <= ST_LEVEL;
              end
            endcase
          end
        end
        ST_LEVEL: begin
          // Divide each component by its divisor, clamped to the step count.
          if (!dv_busy) begin
            if (lev_div == 8'd0) begin
              unique case (lev_idx)
                2'd0: lev_r <= lev_cap;
                2'd1: lev_g <= lev_cap;
                default: lev_b <= lev_cap;
              endcase
              if (lev_idx == 2'd2) begin
                step_rd <= '0;
                rd_ok <= 1'b0;
                state <= ST_RMW;
              end
              lev_idx <= lev_idx + 2'd1;
            end else begin
              dv_busy <= 1'b1;
              dv_cnt <= 5'd16;
              dv_rem <= '0;
              dv_den <= {8'd0, lev_div};
              dv_quo <= {8'd0, lev_comp};
            end
          end else if (dv_cnt != 5'd0) begin
            if (dv_trial >= dv_den) begin
              dv_rem <= dv_trial - dv_den;
              dv_quo <= {dv_quo[14:0], 1'b1};
            end else begin
              dv_rem <= dv_trial;
              dv_quo <= {dv_quo[14:0], 1'b0};
            end
            dv_cnt <= dv_cnt - 5'd1;
          end else begin
            dv_busy <= 1'b0;
            unique case (lev_idx)
              2'd0: lev_r <= (q8 > lev_cap) ? lev_cap : q8;
              2'd1: lev_g <= (q8 > lev_cap) ? lev_cap : q8;
              default: lev_b <= (q8 > lev_cap) ? lev_cap : q8;
            endcase
            if (lev_idx == 2'd2) begin
              step_rd <= '0;
              rd_ok <= 1'b0;
              state <= ST_RMW;
            end
            lev_idx <= lev_idx + 2'd1;
          end
        end
        ST_RMW: begin
          // Each step word is read once and written back the next cycle.
          step_wr <= step_rd;
          wr_addr_q <= base + AW'(step_rd);
          if (rd_ok && step_wr == LAST_STEP) begin
            rd_ok <= 1'b0;
            state <= ST_IDLE;
          end else begin
            rd_ok <= 1'b1;
            if (step_rd != LAST_STEP) step_rd <= step_rd + SW'(1);
          end
        end
        default: state <= ST_INIT;
      endcase
    end
  end

  // A result appears only through the tick path.
  `ASSERT_NEXT(a_out_from_hold, clk, rst, !out_valid && state != ST_HOLD, !out_valid, "stray result")
  // No memory write while idle.
  `ASSERT_IMPL(a_no_idle_write, clk, rst, state == ST_IDLE, !b_we && !c_we, "write while idle")
  // A pixel write touches only one port.
  `ASSERT_IMPL(a_one_port, clk, rst, state == ST_RMW, !(b_we && c_we), "both ports written")

endmodule

FILE: sv/lmpw_ram.sv
module lmpw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
